### rtl/pls_pkg.sv
package pls_pkg;

	localparam int DataW      = 32;
	localparam int PosW       = 6;
	localparam int MaxResults = 32;

	localparam logic [1:0] FN_INSERT = 2'd0;
	localparam logic [1:0] FN_DELETE = 2'd1;
	localparam logic [1:0] FN_SORT   = 2'd2;
	localparam logic [1:0] FN_OUTPUT = 2'd3;

	localparam logic [1:0] STAT_OK  = 2'd0;
	localparam logic [1:0] STAT_ERR = 2'd1;
	localparam logic [1:0] STAT_OVF = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_WR,
		ST_DEL_RD,
		ST_DEL_WR,
		ST_SRT_KEY_RD,
		ST_SRT_KEY_LD,
		ST_SRT_RD,
		ST_SRT_CMP,
		ST_OUT_RD,
		ST_OUT_LD,
		ST_RESP
	} state_t;

endpackage

### rtl/pls_ram.sv
module pls_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/positional_list_with_sort_unit.sv
// Insert and delete: shift each entry past the position one place, a read then a write per entry.
// Sort: in-place insertion sort through one RAM port pair and one comparator.
// Output: reads one item per word and stalls while the result register is full; the result register lets the
//   next word be accepted while the final result waits. One operation at a time.
// arst_n clears the sequencer, count and result valid flag; the store is not cleared.
module positional_list_with_sort_unit #(
	parameter int CAPACITY = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // [5:0] position, [37:6] value, [39:38] zero
	input  logic [1:0]  s_tuser,  // [1:0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [31:0] item
	output logic [1:0]  m_tuser,  // [1:0] status
	output logic        m_tlast
);

	import pls_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW + 2 > 7) ? CW + 2 : 7;
	localparam logic signed [XW-1:0] MinusOne = '1;

	state_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] jdx_q, jdx_d;
	logic [CW-1:0] at_q, at_d;
	logic [DataW-1:0] key_q, key_d;
	logic [1:0] res_q, res_d;

	logic out_valid_q;
	logic [1:0] out_status_q;
	logic [DataW-1:0] out_item_q;
	logic out_last_q;
	logic out_load;
	logic [1:0] out_status_d;
	logic [DataW-1:0] out_item_d;
	logic out_last_d;

	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [DataW-1:0] ram_wdata, ram_rdata;

	logic [1:0] in_func;
	logic [PosW-1:0] in_pos;
	logic [DataW-1:0] in_value;
	logic signed [XW-1:0] pos_x, cnt_x;
	logic [XW-1:0] at_x, idx_x, cnt_u;
	logic ins_ok, del_ok, full, out_hit_last;
	logic [CW-1:0] idx_m1, idx_p1, jdx_m1;

	assign in_func  = s_tuser[1:0];
	assign in_pos   = s_tdata[5:0];
	assign in_value = s_tdata[37:6];

	assign pos_x  = signed'({{(XW - PosW){in_pos[PosW-1]}}, in_pos});
	assign cnt_u  = XW'(count_q);
	assign cnt_x  = signed'(cnt_u);
	assign at_x   = XW'(pos_x) + XW'(1);
	assign ins_ok = (pos_x >= MinusOne) && (pos_x < cnt_x);
	assign del_ok = !pos_x[XW-1] && (pos_x < cnt_x);
	assign full   = count_q >= CW'(CAPACITY);
	assign idx_x  = XW'(idx_q);
	assign idx_m1 = idx_q - 1'b1;
	assign idx_p1 = idx_q + 1'b1;
	assign jdx_m1 = jdx_q - 1'b1;
	assign out_hit_last = (idx_x + XW'(1) == cnt_u) || (idx_x + XW'(1) == XW'(MaxResults));

	assign s_tready = (state_q == ST_IDLE);

	pls_ram #(
		.WIDTH(DataW),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		idx_d        = idx_q;
		jdx_d        = jdx_q;
		at_d         = at_q;
		key_d        = key_q;
		res_d        = res_q;
		ram_we       = 1'b0;
		ram_waddr    = idx_q[AW-1:0];
		ram_wdata    = key_q;
		ram_raddr    = idx_q[AW-1:0];
		out_load     = 1'b0;
		out_status_d = STAT_OK;
		out_item_d   = '0;
		out_last_d   = 1'b1;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					res_d = STAT_OK;
					case (in_func)
						FN_INSERT: begin
							key_d = in_value;
							at_d  = at_x[CW-1:0];
							idx_d = count_q;
							if (!ins_ok) begin
								res_d   = STAT_ERR;
								state_d = ST_RESP;
							end else if (full) begin
								res_d   = STAT_OVF;
								state_d = ST_RESP;
							end else begin
								state_d = ST_INS_RD;
							end
						end
						FN_DELETE: begin
							idx_d = pos_x[CW-1:0];
							if (!del_ok) begin
								res_d   = STAT_ERR;
								state_d = ST_RESP;
							end else begin
								state_d = ST_DEL_RD;
							end
						end
						FN_SORT: begin
							idx_d   = CW'(1);
							state_d = ST_SRT_KEY_RD;
						end
						default: begin
							idx_d = '0;
							if (count_q == '0) begin
								res_d   = STAT_ERR;
								state_d = ST_RESP;
							end else begin
								state_d = ST_OUT_RD;
							end
						end
					endcase
				end
			end
			ST_INS_RD: begin
				if (idx_q > at_q) begin
					ram_raddr = idx_m1[AW-1:0];
					state_d   = ST_INS_WR;
				end else begin
					ram_we    = 1'b1;
					ram_wdata = key_q;
					count_d   = count_q + 1'b1;
					state_d   = ST_RESP;
				end
			end
			ST_INS_WR: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
				idx_d     = idx_m1;
				state_d   = ST_INS_RD;
			end
			ST_DEL_RD: begin
				if (idx_x + XW'(1) < cnt_u) begin
					ram_raddr = idx_p1[AW-1:0];
					state_d   = ST_DEL_WR;
				end else begin
					count_d = count_q - 1'b1;
					state_d = ST_RESP;
				end
			end
			ST_DEL_WR: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
				idx_d     = idx_p1;
				state_d   = ST_DEL_RD;
			end
			ST_SRT_KEY_RD: begin
				if (idx_q < count_q) begin
					state_d = ST_SRT_KEY_LD;
				end else begin
					state_d = ST_RESP;
				end
			end
			ST_SRT_KEY_LD: begin
				key_d   = ram_rdata;
				jdx_d   = idx_q;
				state_d = ST_SRT_RD;
			end
			ST_SRT_RD: begin
				ram_raddr = jdx_m1[AW-1:0];
				ram_waddr = jdx_q[AW-1:0];
				if (jdx_q != '0) begin
					state_d = ST_SRT_CMP;
				end else begin
					ram_we  = 1'b1;
					idx_d   = idx_p1;
					state_d = ST_SRT_KEY_RD;
				end
			end
			ST_SRT_CMP: begin
				ram_we    = 1'b1;
				ram_waddr = jdx_q[AW-1:0];
				if ($signed(ram_rdata) > $signed(key_q)) begin
					ram_wdata = ram_rdata;
					jdx_d     = jdx_m1;
					state_d   = ST_SRT_RD;
				end else begin
					idx_d   = idx_p1;
					state_d = ST_SRT_KEY_RD;
				end
			end
			ST_OUT_RD: begin
				if (!out_valid_q) begin
					state_d = ST_OUT_LD;
				end
			end
			ST_OUT_LD: begin
				out_load   = 1'b1;
				out_item_d = ram_rdata;
				out_last_d = out_hit_last;
				idx_d      = idx_p1;
				state_d    = out_hit_last ? ST_IDLE : ST_OUT_RD;
			end
			ST_RESP: begin
				if (!out_valid_q) begin
					out_load     = 1'b1;
					out_status_d = res_q;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		jdx_q <= jdx_d;
		at_q  <= at_d;
		key_q <= key_d;
		res_q <= res_d;
		if (out_load) begin
			out_status_q <= out_status_d;
			out_item_q   <= out_item_d;
			out_last_q   <= out_last_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_item_q;
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("element count above capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		((count_q == $past(count_q) + 1'b1) || (count_q == $past(count_q) - 1'b1)))
		else $error("element count moved by more than one");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != STAT_OK)) |-> m_tlast)
		else $error("error word without last");

	a_we_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q != ST_IDLE) && !s_tready)
		else $error("store written while idle");

endmodule
